/* sv/mix_hash_node_combiner_top_assert.svh */
// assertion macros for the hash combiner
`ifndef MIX_HASH_NODE_COMBINER_TOP_ASSERT_SVH
`define MIX_HASH_NODE_COMBINER_TOP_ASSERT_SVH

// same-cycle implication
`define MHNC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhnc assertion failed");

// next-cycle implication
`define MHNC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhnc assertion failed");

`endif

/* sv/mhnc_pkg.sv */
package mhnc_pkg;

    localparam logic [63:0] HASH_SEED = 64'h4c1f17a3de7b9213;
    localparam logic [63:0] GOLDEN_K  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] FIN_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] FIN_MUL_B = 64'h94d049bb133111eb;

    localparam int unsigned DIGEST_CHARS = 64;
    localparam int unsigned IDX_W        = $clog2(DIGEST_CHARS);

    typedef logic [63:0] word_t;
    typedef logic [2:0]  state_t;

    localparam state_t ST_IDLE = 3'd0;
    localparam state_t ST_XS   = 3'd1;
    localparam state_t ST_M0   = 3'd2;
    localparam state_t ST_M1   = 3'd3;
    localparam state_t ST_M2   = 3'd4;
    localparam state_t ST_M3   = 3'd5;
    localparam state_t ST_FIN  = 3'd6;
    localparam state_t ST_EMIT = 3'd7;

    // hash-combine front end of one mix step
    function automatic word_t combine(input word_t h, input word_t v);
        word_t sum;
        sum = v + GOLDEN_K + (h << 6) + (h >> 2);
        return h ^ sum;
    endfunction

    function automatic logic [6:0] nibble_char(input logic [3:0] n);
        logic [6:0] c;
        if (n < 4'd10)
        begin
            c = 7'h30 + {3'b000, n};
        end
        else
        begin
            c = 7'h57 + {3'b000, n};
        end
        return c;
    endfunction

endpackage

/* sv/mix_hash_node_combiner_top.sv */
// each accepted byte is combined into the hash, then mixed by two xorshift-multiply passes and a final xorshift
// ready stays low until the mix is done; one shared 32x32 multiplier serves both passes (6 products per byte)
// digest: after a last byte, 64 hex chars follow, two per digest byte with a remix between pairs, plus output stalls
// the char register lets the next message's bytes be taken while the final char waits
// reset: asynchronous active-low rst_n; hash returns to the seed, no request pending
module mix_hash_node_combiner_top
    import mhnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] hex_char, [7] zero pad
    output logic       m_tlast    // last_char
);

    state_t           state_reg, state_next;
    logic             pass_reg, pass_next;
    logic             emit_reg, emit_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    word_t            hash_reg, hash_next;
    word_t            op_reg, op_next;
    word_t            acc_reg, acc_next;
    word_t            prod_reg, prod_next;
    logic             out_valid_reg, out_valid_next;
    logic [6:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    logic [31:0] mul_x, mul_y;
    word_t       mul_c;
    word_t       in_ext;
    word_t       round_v;
    logic [4:0]  round_i;
    logic [7:0]  digest_byte;
    logic [3:0]  digest_nib;
    logic        out_load;
    logic        in_accept;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_char_reg};
    assign m_tlast   = out_last_reg;

    assign in_ext  = {{56{s_tdata[7]}}, s_tdata};
    assign round_i = idx_reg[IDX_W-1:1];
    // i*17 + 31 fits in ten bits
    assign round_v = {54'd0, ({1'b0, round_i, 4'b0000} + {5'd0, round_i} + 10'd31)};

    assign digest_byte = hash_reg[{idx_reg[3:1], 3'b000} +: 8];
    assign digest_nib  = idx_reg[0] ? digest_byte[3:0] : digest_byte[7:4];
    assign out_load    = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    // shared multiplier: low 64 bits of op * const from three 32x32 products
    assign mul_c = pass_reg ? FIN_MUL_B : FIN_MUL_A;
    assign mul_x = (state_reg == ST_M2) ? op_reg[63:32] : op_reg[31:0];
    assign mul_y = (state_reg == ST_M1) ? mul_c[63:32] : mul_c[31:0];

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        emit_next      = emit_reg;
        idx_next       = idx_reg;
        hash_next      = hash_reg;
        op_next        = op_reg;
        acc_next       = acc_reg;
        prod_next      = {32'd0, mul_x} * {32'd0, mul_y};
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    hash_next  = combine(hash_reg, in_ext);
                    emit_next  = s_tlast;
                    idx_next   = '0;
                    pass_next  = 1'b0;
                    state_next = ST_XS;
                end
            end
            ST_XS:
            begin
                op_next    = pass_reg ? (acc_reg ^ (acc_reg >> 27)) : (hash_reg ^ (hash_reg >> 30));
                state_next = ST_M0;
            end
            ST_M0:
            begin
                state_next = ST_M1;
            end
            ST_M1:
            begin
                acc_next   = prod_reg;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                acc_next   = acc_reg + {prod_reg[31:0], 32'd0};
                state_next = ST_M3;
            end
            ST_M3:
            begin
                acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                if (pass_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    pass_next  = 1'b1;
                    state_next = ST_XS;
                end
            end
            ST_FIN:
            begin
                hash_next  = acc_reg ^ (acc_reg >> 31);
                state_next = emit_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = nibble_char(digest_nib);
                    out_last_next  = (idx_reg == IDX_W'(DIGEST_CHARS - 1));
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(DIGEST_CHARS - 1))
                    begin
                        hash_next  = HASH_SEED;
                        emit_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else if (idx_reg[0])
                    begin
                        // byte done: remix before the next digest byte
                        hash_next  = combine(hash_reg, round_v);
                        pass_next  = 1'b0;
                        state_next = ST_XS;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= 1'b0;
            emit_reg      <= 1'b0;
            idx_reg       <= '0;
            hash_reg      <= HASH_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            emit_reg      <= emit_next;
            idx_reg       <= idx_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

`include "mix_hash_node_combiner_top_assert.svh"

    `MHNC_ASSERT_NOW(a_no_input_during_digest, s_tready, !emit_reg)
    `MHNC_ASSERT_NEXT(a_second_pass_finishes, (state_reg == ST_M3) && pass_reg, state_reg == ST_FIN)
    `MHNC_ASSERT_NOW(a_hex_char_range, m_tvalid,
        ((m_tdata[6:0] >= 7'h30) && (m_tdata[6:0] <= 7'h39)) ||
        ((m_tdata[6:0] >= 7'h61) && (m_tdata[6:0] <= 7'h66)))

endmodule
